FILE: rtl/vrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex rigid transform package
// Shared widths, register indexes, payload types and the saturation helper.
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam int COORD_W    = 32;
    localparam int TRIG_W     = 18;
    localparam int ROT_W      = 2 * TRIG_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROT_W;
    // Product of a coordinate and a sine that may have been negated.
    localparam int PROD_W     = COORD_W + TRIG_W + 1;
    localparam int SAT_IN_W   = PROD_W + 1;
    // Register stages from an accepted item to its result strobe.
    localparam int PIPE_LATENCY = 8;

    localparam logic REQ_FWD = 1'b0;
    localparam logic REQ_INV = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROT_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOC_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOC_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOC_Z = 3'd5;

    // Cosine 1.0, sine 0.
    localparam logic [ROT_W-1:0] ROT_RESET = 36'h4_0000_0000;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
    } t_vrt_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      clipped;
    } t_vrt_out;

    typedef struct packed {
        logic [ROT_W-1:0]          rot_x;
        logic [ROT_W-1:0]          rot_y;
        logic [ROT_W-1:0]          rot_z;
        logic signed [COORD_W-1:0] loc_x;
        logic signed [COORD_W-1:0] loc_y;
        logic signed [COORD_W-1:0] loc_z;
    } t_vrt_cfg;

    // Vertex as it travels down the pipeline.
    typedef struct packed {
        logic                      req;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      clip;
    } t_vec;

    typedef struct packed {
        logic signed [COORD_W-1:0] val;
        logic                      clip;
    } t_sat;

    function automatic t_sat f_sat(input logic signed [SAT_IN_W-1:0] v);
        t_sat r;
        if (v > SAT_IN_W'(COORD_MAX)) begin
            r.val  = COORD_MAX;
            r.clip = 1'b1;
        end else if (v < SAT_IN_W'(COORD_MIN)) begin
            r.val  = COORD_MIN;
            r.clip = 1'b1;
        end else begin
            r.val  = v[COORD_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: rtl/vrt_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the three rotation pairs and the location; written one at a time.
// ----------------------------------------------------------------------------
module vrt_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vrt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vrt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output vrt_pkg::t_vrt_cfg             o_cfg
);
    import vrt_pkg::*;

    t_vrt_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_x <= ROT_RESET;
            r_cfg.rot_y <= ROT_RESET;
            r_cfg.rot_z <= ROT_RESET;
            r_cfg.loc_x <= '0;
            r_cfg.loc_y <= '0;
            r_cfg.loc_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROT_X: r_cfg.rot_x <= i_cfg_data;
                REG_ROT_Y: r_cfg.rot_y <= i_cfg_data;
                REG_ROT_Z: r_cfg.rot_z <= i_cfg_data;
                REG_LOC_X: r_cfg.loc_x <= i_cfg_data[COORD_W-1:0];
                REG_LOC_Y: r_cfg.loc_y <= i_cfg_data[COORD_W-1:0];
                REG_LOC_Z: r_cfg.loc_z <= i_cfg_data[COORD_W-1:0];
                default: begin
                    // Indexes past the last register are ignored.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/vrt_trans_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Translation stage
// Adds or subtracts the location with saturation, for one request type only.
// ----------------------------------------------------------------------------
module vrt_trans_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sub,
    input  vrt_pkg::t_vrt_cfg i_cfg,
    input  logic              i_valid,
    input  vrt_pkg::t_vec     i_vec,
    output logic              o_valid,
    output vrt_pkg::t_vec     o_vec
);
    import vrt_pkg::*;

    logic  r_valid;
    t_vec  r_vec;
    t_vec  n_vec;
    logic  w_en;
    t_sat  w_sx;
    t_sat  w_sy;
    t_sat  w_sz;
    logic signed [COORD_W:0] w_dx;
    logic signed [COORD_W:0] w_dy;
    logic signed [COORD_W:0] w_dz;

    // Subtraction belongs to inverse requests, addition to forward ones.
    assign w_en = (i_vec.req == (i_sub ? REQ_INV : REQ_FWD));

    always_comb begin
        if (i_sub) begin
            w_dx = (COORD_W+1)'(i_vec.x) - (COORD_W+1)'(i_cfg.loc_x);
            w_dy = (COORD_W+1)'(i_vec.y) - (COORD_W+1)'(i_cfg.loc_y);
            w_dz = (COORD_W+1)'(i_vec.z) - (COORD_W+1)'(i_cfg.loc_z);
        end else begin
            w_dx = (COORD_W+1)'(i_vec.x) + (COORD_W+1)'(i_cfg.loc_x);
            w_dy = (COORD_W+1)'(i_vec.y) + (COORD_W+1)'(i_cfg.loc_y);
            w_dz = (COORD_W+1)'(i_vec.z) + (COORD_W+1)'(i_cfg.loc_z);
        end
        w_sx = f_sat(SAT_IN_W'(w_dx));
        w_sy = f_sat(SAT_IN_W'(w_dy));
        w_sz = f_sat(SAT_IN_W'(w_dz));
        n_vec = i_vec;
        if (w_en) begin
            n_vec.x    = w_sx.val;
            n_vec.y    = w_sy.val;
            n_vec.z    = w_sz.val;
            n_vec.clip = i_vec.clip | w_sx.clip | w_sy.clip | w_sz.clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_vec <= n_vec;
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

FILE: rtl/vrt_rot_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation stage
// Rotates one coordinate pair: four products, then round and saturate.
// ----------------------------------------------------------------------------
module vrt_rot_stage #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vrt_pkg::t_axis    i_fwd_axis,
    input  vrt_pkg::t_axis    i_inv_axis,
    input  vrt_pkg::t_vrt_cfg i_cfg,
    input  logic              i_valid,
    input  vrt_pkg::t_vec     i_vec,
    output logic              o_valid,
    output vrt_pkg::t_vec     o_vec
);
    import vrt_pkg::*;

    localparam logic signed [SAT_IN_W-1:0] RND_HALF =
        SAT_IN_W'(1) <<< (FRAC_BITS - 1);

    // Product stage.
    t_axis                      w_axis;
    logic [ROT_W-1:0]           w_rot;
    logic signed [COORD_W-1:0]  w_a;
    logic signed [COORD_W-1:0]  w_b;
    logic signed [TRIG_W-1:0]   w_cos;
    logic signed [TRIG_W-1:0]   w_sin;
    logic signed [TRIG_W:0]     w_sin_eff;

    logic                       r_valid_p;
    t_vec                       r_vec_p;
    t_axis                      r_axis;
    logic signed [PROD_W-1:0]   r_ac;
    logic signed [PROD_W-1:0]   r_bs;
    logic signed [PROD_W-1:0]   r_as;
    logic signed [PROD_W-1:0]   r_bc;

    // Sum stage.
    logic signed [SAT_IN_W-1:0] w_na;
    logic signed [SAT_IN_W-1:0] w_nb;
    t_sat                       w_sa;
    t_sat                       w_sb;
    t_vec                       n_vec;
    logic                       r_valid;
    t_vec                       r_vec;

    always_comb begin
        w_axis = (i_vec.req == REQ_FWD) ? i_fwd_axis : i_inv_axis;
        case (w_axis)
            AXIS_X: begin
                w_rot = i_cfg.rot_x;
                w_a   = i_vec.y;
                w_b   = i_vec.z;
            end
            AXIS_Y: begin
                w_rot = i_cfg.rot_y;
                w_a   = i_vec.z;
                w_b   = i_vec.x;
            end
            AXIS_Z: begin
                w_rot = i_cfg.rot_z;
                w_a   = i_vec.x;
                w_b   = i_vec.y;
            end
            default: begin
                w_rot = i_cfg.rot_z;
                w_a   = i_vec.x;
                w_b   = i_vec.y;
            end
        endcase
        w_cos = $signed(w_rot[ROT_W-1:TRIG_W]);
        w_sin = $signed(w_rot[TRIG_W-1:0]);
        // Inverse requests turn by the negated angle; one extra bit keeps -(-2.0).
        w_sin_eff = (i_vec.req == REQ_INV) ? -(TRIG_W+1)'(w_sin) : (TRIG_W+1)'(w_sin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_p <= 1'b0;
        end else begin
            r_valid_p <= i_valid;
        end
        r_vec_p <= i_vec;
        r_axis  <= w_axis;
        r_ac    <= PROD_W'(w_a) * PROD_W'(w_cos);
        r_bs    <= PROD_W'(w_b) * PROD_W'(w_sin_eff);
        r_as    <= PROD_W'(w_a) * PROD_W'(w_sin_eff);
        r_bc    <= PROD_W'(w_b) * PROD_W'(w_cos);
    end

    always_comb begin
        // Round half up: add one half, then an arithmetic shift floors.
        w_na = ((SAT_IN_W'(r_ac) - SAT_IN_W'(r_bs)) + RND_HALF) >>> FRAC_BITS;
        w_nb = ((SAT_IN_W'(r_as) + SAT_IN_W'(r_bc)) + RND_HALF) >>> FRAC_BITS;
        w_sa = f_sat(w_na);
        w_sb = f_sat(w_nb);
        n_vec = r_vec_p;
        n_vec.clip = r_vec_p.clip | w_sa.clip | w_sb.clip;
        case (r_axis)
            AXIS_X: begin
                n_vec.y = w_sa.val;
                n_vec.z = w_sb.val;
            end
            AXIS_Y: begin
                n_vec.z = w_sa.val;
                n_vec.x = w_sb.val;
            end
            AXIS_Z: begin
                n_vec.x = w_sa.val;
                n_vec.y = w_sb.val;
            end
            default: begin
                n_vec.x = w_sa.val;
                n_vec.y = w_sb.val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_valid_p;
        end
        r_vec <= n_vec;
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

FILE: rtl/vertex_rigid_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex rigid transform
// Rotates a vertex about X, Z, Y and translates it, or undoes that transform.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Transfer
//  -------   ------------------------------   --------------------------------
//  command   start, busy, i_item              start high and busy low at edge
//  result    o_strobe, o_result               o_strobe high, one cycle only
//  config    i_cfg_we, i_cfg_idx, i_cfg_data  i_cfg_we high at edge
//
// A vertex can be started in every cycle; its result passes through the
// pipeline: one translation stage, three
// rotation stages of two registers each (products, then round and saturate),
// and a second translation stage. Busy is high only while reset is held.
// Reset is synchronous and active low; it clears the valid bits of every
// stage, so any vertex in flight is dropped. The receiver cannot stall.
// The user must write configuration only while no vertex is in flight; the
// block does not enforce this. The stages read the registers directly.
//
// A forward request skips the first translation stage and rotates about X,
// Z, Y before adding the location. An inverse request subtracts the location
// first, skips the last stage and rotates by negated angles about Y, Z, X.
// Every saturation along the way sets the clipped flag of the result.
// ----------------------------------------------------------------------------
module vertex_rigid_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  vrt_pkg::t_vrt_in               i_item,
    output logic                           o_strobe,
    output vrt_pkg::t_vrt_out              o_result,
    input  logic                           i_cfg_we,
    input  logic [vrt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vrt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import vrt_pkg::*;

    t_vrt_cfg w_cfg;
    logic     w_in_valid;
    t_vec     w_in_vec;
    logic     w_pre_valid;
    t_vec     w_pre_vec;
    logic     w_r1_valid;
    t_vec     w_r1_vec;
    logic     w_r2_valid;
    t_vec     w_r2_vec;
    logic     w_r3_valid;
    t_vec     w_r3_vec;
    logic     w_post_valid;
    t_vec     w_post_vec;

    assign busy       = ~i_rst_n;
    assign w_in_valid = start & ~busy;

    assign w_in_vec.req  = i_item.req_type;
    assign w_in_vec.x    = i_item.in_x;
    assign w_in_vec.y    = i_item.in_y;
    assign w_in_vec.z    = i_item.in_z;
    assign w_in_vec.clip = 1'b0;

    vrt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Inverse requests subtract the location before any rotation.
    vrt_trans_stage u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sub   (1'b1),
        .i_cfg   (w_cfg),
        .i_valid (w_in_valid),
        .i_vec   (w_in_vec),
        .o_valid (w_pre_valid),
        .o_vec   (w_pre_vec)
    );

    vrt_rot_stage #(.FRAC_BITS(FRAC_BITS)) u_rot1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fwd_axis (AXIS_X),
        .i_inv_axis (AXIS_Y),
        .i_cfg      (w_cfg),
        .i_valid    (w_pre_valid),
        .i_vec      (w_pre_vec),
        .o_valid    (w_r1_valid),
        .o_vec      (w_r1_vec)
    );

    vrt_rot_stage #(.FRAC_BITS(FRAC_BITS)) u_rot2 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fwd_axis (AXIS_Z),
        .i_inv_axis (AXIS_Z),
        .i_cfg      (w_cfg),
        .i_valid    (w_r1_valid),
        .i_vec      (w_r1_vec),
        .o_valid    (w_r2_valid),
        .o_vec      (w_r2_vec)
    );

    vrt_rot_stage #(.FRAC_BITS(FRAC_BITS)) u_rot3 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fwd_axis (AXIS_Y),
        .i_inv_axis (AXIS_X),
        .i_cfg      (w_cfg),
        .i_valid    (w_r2_valid),
        .i_vec      (w_r2_vec),
        .o_valid    (w_r3_valid),
        .o_vec      (w_r3_vec)
    );

    // Forward requests add the location after the last rotation.
    vrt_trans_stage u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sub   (1'b0),
        .i_cfg   (w_cfg),
        .i_valid (w_r3_valid),
        .i_vec   (w_r3_vec),
        .o_valid (w_post_valid),
        .o_vec   (w_post_vec)
    );

    assign o_strobe         = w_post_valid;
    assign o_result.out_x   = w_post_vec.x;
    assign o_result.out_y   = w_post_vec.y;
    assign o_result.out_z   = w_post_vec.z;
    assign o_result.clipped = w_post_vec.clip;

endmodule

FILE: rtl/vrt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex rigid transform checker
// Watches the top-level ports for latency, reset behavior and a known clipped flag.
// ----------------------------------------------------------------------------
module vrt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_strobe,
    input vrt_pkg::t_vrt_out   o_result
);
    import vrt_pkg::*;

    // Every started vertex yields exactly one result after the pipeline latency.
    a_start_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LATENCY o_strobe)
        else $error("transfer without result after pipeline latency");

    a_result_has_start: assert property (@(posedge i_clk)
        o_strobe |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result strobe without a matching transfer");

    // Reset drops everything in flight.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    // A strobed result never carries unknown clip state.
    a_clip_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !$isunknown(o_result.clipped))
        else $error("clipped flag unknown on a result");

endmodule

bind vertex_rigid_transform vrt_checker u_vrt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
